// File: src/sitda_pkg.sv
package sitda_pkg;

    localparam int VALUE_W = 32;
    localparam int CHAR_W = 8;
    localparam int DIGIT_W = 4;
    localparam int MAX_DIGITS = 10;
    localparam int NDIG_W = 4;

    localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd48;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;

    // Reciprocal of ten scaled by 2^35, so that floor(x / 10) = (x * RECIP10) >> 35.
    localparam logic [VALUE_W-1:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RECIP10_SHIFT = 35;

    typedef struct packed {
        logic load;
        logic divide;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_last;
        logic chars_left;
    } ctrl_status_t;

endpackage

// File: src/signed_int_to_decimal_ascii_core.sv
// Converts one signed 32-bit integer into its decimal ASCII text.
// Input channel: value with value_valid / value_ready. Output channel:
// ascii_char and last_char with char_valid / char_ready, one character per
// item, most significant first, a leading '-' for negative numbers, and
// last_char set on the final character of each number.
// A number is taken only while the block is idle. The magnitude is then
// divided by ten once per cycle through a reciprocal multiplier, one digit
// per division (1 to 10 digits), and the characters are shifted out one
// per cycle while the receiver accepts them. A number gives D characters,
// where D is the digit count, or D + 1 with the sign. The next number is
// taken only after the last character of this one has been accepted, as
// the single shared divide step and the emission sequence serve one number
// at a time.
// When the receiver holds char_ready low, the current character stays in
// the output register and conversion of the next number waits.
// Reset clears the controller and drops char_valid; any number in progress
// is discarded.
module signed_int_to_decimal_ascii_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [sitda_pkg::VALUE_W-1:0]         value,
    input  logic                                  value_valid,
    output logic                                  value_ready,
    output logic [sitda_pkg::CHAR_W-1:0]          ascii_char,
    output logic                                  last_char,
    output logic                                  char_valid,
    input  logic                                  char_ready
);

    sitda_pkg::ctrl_cmd_t    cmd;
    sitda_pkg::ctrl_status_t status;

    sitda_controller u_controller (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .status      (status),
        .cmd         (cmd)
    );

    sitda_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .cmd         (cmd),
        .status      (status),
        .ascii_char  (ascii_char),
        .last_char   (last_char)
    );

endmodule

// File: src/sitda_datapath.sv
module sitda_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [sitda_pkg::VALUE_W-1:0]         value,
    input  sitda_pkg::ctrl_cmd_t                  cmd,
    output sitda_pkg::ctrl_status_t               status,
    output logic [sitda_pkg::CHAR_W-1:0]          ascii_char,
    output logic                                  last_char
);

    logic [sitda_pkg::VALUE_W-1:0]   mag_reg;
    logic [sitda_pkg::VALUE_W-1:0]   mag_next;
    logic                            sign_reg;
    logic                            sign_next;
    logic [sitda_pkg::DIGIT_W-1:0]   digits_reg [sitda_pkg::MAX_DIGITS];
    logic [sitda_pkg::DIGIT_W-1:0]   digits_next [sitda_pkg::MAX_DIGITS];
    logic [sitda_pkg::NDIG_W-1:0]    ndig_reg;
    logic [sitda_pkg::NDIG_W-1:0]    ndig_next;
    logic [sitda_pkg::CHAR_W-1:0]    char_reg;
    logic [sitda_pkg::CHAR_W-1:0]    char_next;
    logic                            last_reg;
    logic                            last_next;

    logic [2*sitda_pkg::VALUE_W-1:0] prod;
    logic [sitda_pkg::VALUE_W-1:0]   quot;
    logic [sitda_pkg::VALUE_W-1:0]   quot_x10;
    logic [sitda_pkg::VALUE_W-1:0]   rem_full;
    logic [sitda_pkg::DIGIT_W-1:0]   rem;

    always_comb
    begin
        prod     = {{sitda_pkg::VALUE_W{1'b0}}, mag_reg}
                 * {{sitda_pkg::VALUE_W{1'b0}}, sitda_pkg::RECIP10};
        quot     = sitda_pkg::VALUE_W'(prod >> sitda_pkg::RECIP10_SHIFT);
        quot_x10 = (quot << 3) + (quot << 1);
        rem_full = mag_reg - quot_x10;
        rem      = rem_full[sitda_pkg::DIGIT_W-1:0];
    end

    assign status.div_last   = (quot == '0);
    assign status.chars_left = sign_reg || (ndig_reg != '0);

    always_comb
    begin
        mag_next  = mag_reg;
        sign_next = sign_reg;
        ndig_next = ndig_reg;
        char_next = char_reg;
        last_next = last_reg;
        for (int k = 0; k < sitda_pkg::MAX_DIGITS; k++)
        begin
            digits_next[k] = digits_reg[k];
        end

        if (cmd.load)
        begin
            sign_next = value[sitda_pkg::VALUE_W-1];
            mag_next  = value[sitda_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
            ndig_next = '0;
        end
        else if (cmd.divide)
        begin
            mag_next       = quot;
            ndig_next      = ndig_reg + 1'b1;
            digits_next[0] = rem;
            for (int k = 1; k < sitda_pkg::MAX_DIGITS; k++)
            begin
                digits_next[k] = digits_reg[k-1];
            end
        end
        else if (cmd.emit)
        begin
            if (sign_reg)
            begin
                char_next = sitda_pkg::MINUS_CHAR;
                last_next = 1'b0;
                sign_next = 1'b0;
            end
            else
            begin
                char_next = sitda_pkg::DIGIT_BASE
                          + {{(sitda_pkg::CHAR_W-sitda_pkg::DIGIT_W){1'b0}}, digits_reg[0]};
                last_next = (ndig_reg == sitda_pkg::NDIG_W'(1));
                ndig_next = ndig_reg - 1'b1;
                for (int k = 0; k < sitda_pkg::MAX_DIGITS - 1; k++)
                begin
                    digits_next[k] = digits_reg[k+1];
                end
                digits_next[sitda_pkg::MAX_DIGITS-1] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        char_reg <= char_next;
        last_reg <= last_next;
        for (int k = 0; k < sitda_pkg::MAX_DIGITS; k++)
        begin
            digits_reg[k] <= digits_next[k];
        end
    end

    // Sign and digit count steer the controller, so they are reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_reg <= 1'b0;
            ndig_reg <= '0;
        end
        else
        begin
            sign_reg <= sign_next;
            ndig_reg <= ndig_next;
        end
    end

    assign ascii_char = char_reg;
    assign last_char  = last_reg;

endmodule

// File: src/sitda_controller.sv
module sitda_controller (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     value_valid,
    output logic                     value_ready,
    output logic                     char_valid,
    input  logic                     char_ready,
    input  sitda_pkg::ctrl_status_t  status,
    output sitda_pkg::ctrl_cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       valid_reg;
    logic       valid_next;
    logic       out_free;

    assign out_free    = !valid_reg || char_ready;
    assign value_ready = (state_reg == ST_IDLE);
    assign char_valid  = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (value_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.divide = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (status.chars_left)
                    begin
                        cmd.emit   = 1'b1;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        valid_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule
